@@ rtl/csh_pkg.sv @@
// cbor stream head decoder: shared types and constants
// used by csh_decode, cbor_stream_head_decoder and csh_checker
package csh_pkg;

	typedef enum logic [1:0] {
		PH_INITIAL = 2'd0,
		PH_ARG     = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_DROP    = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		KIND_HEAD    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_RESERVED  = 2'd1,
		ERR_TRUNCATED = 2'd2
	} err_t;

	localparam logic [4:0] INFO_DIRECT_MAX  = 5'd23;
	localparam logic [4:0] INFO_ONE_BYTE    = 5'd24;
	localparam logic [4:0] INFO_TWO_BYTES   = 5'd25;
	localparam logic [4:0] INFO_FOUR_BYTES  = 5'd26;
	localparam logic [4:0] INFO_EIGHT_BYTES = 5'd27;

	localparam logic [2:0] MAJOR_BYTES = 3'd2;
	localparam logic [2:0] MAJOR_TEXT  = 3'd3;

	typedef struct packed {
		logic        emit;
		kind_t       kind;
		logic [2:0]  major_type;
		logic [63:0] argument;
		logic [7:0]  payload_byte;
		logic        payload_last;
		err_t        error_code;
	} result_t;

endpackage

@@ rtl/csh_decode.sv @@
// cbor head decode state machine: phase, argument gathering, payload countdown
// depends on csh_pkg; the result is registered by the top level
module csh_decode import csh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        message_end,
	output result_t     res
);

	phase_t      phase_q, phase_d;
	logic [2:0]  held_major_q, held_major_d;
	logic [3:0]  arg_left_q, arg_left_d;
	logic [63:0] arg_accum_q, arg_accum_d;
	logic [63:0] payload_left_q, payload_left_d;

	logic        hd_go;
	logic [2:0]  hd_major;
	logic [63:0] hd_arg;
	logic [2:0]  major;
	logic [4:0]  info;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q        <= PH_INITIAL;
			held_major_q   <= '0;
			arg_left_q     <= '0;
			arg_accum_q    <= '0;
			payload_left_q <= '0;
		end else if (take) begin
			phase_q        <= phase_d;
			held_major_q   <= held_major_d;
			arg_left_q     <= arg_left_d;
			arg_accum_q    <= arg_accum_d;
			payload_left_q <= payload_left_d;
		end
	end

	always_comb begin
		phase_d        = phase_q;
		held_major_d   = held_major_q;
		arg_left_d     = arg_left_q;
		arg_accum_d    = arg_accum_q;
		payload_left_d = payload_left_q;
		res            = '0;
		res.kind       = KIND_HEAD;
		res.error_code = ERR_NONE;
		hd_go          = 1'b0;
		hd_major       = held_major_q;
		hd_arg         = arg_accum_q;
		major          = data_byte[7:5];
		info           = data_byte[4:0];

		unique case (phase_q)
			PH_INITIAL: begin
				if (info <= INFO_DIRECT_MAX) begin
					hd_go    = 1'b1;
					hd_major = major;
					hd_arg   = {59'd0, info};
				end else if (info > INFO_EIGHT_BYTES) begin
					res.emit       = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_RESERVED;
					phase_d        = message_end ? PH_INITIAL : PH_DROP;
				end else begin
					held_major_d = major;
					arg_accum_d  = '0;
					priority case (info)
						INFO_ONE_BYTE:   arg_left_d = 4'd1;
						INFO_TWO_BYTES:  arg_left_d = 4'd2;
						INFO_FOUR_BYTES: arg_left_d = 4'd4;
						default:         arg_left_d = 4'd8;
					endcase
					if (message_end) begin
						res.emit       = 1'b1;
						res.kind       = KIND_ERROR;
						res.error_code = ERR_TRUNCATED;
						phase_d        = PH_INITIAL;
					end else begin
						phase_d = PH_ARG;
					end
				end
			end
			PH_ARG: begin
				arg_accum_d = {arg_accum_q[55:0], data_byte};
				arg_left_d  = arg_left_q - {3'd0, (arg_left_q != 4'd0)};
				if (arg_left_d == 4'd0) begin
					hd_go    = 1'b1;
					hd_major = held_major_q;
					hd_arg   = arg_accum_d;
				end else if (message_end) begin
					res.emit       = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_TRUNCATED;
					phase_d        = PH_INITIAL;
				end
			end
			PH_PAYLOAD: begin
				payload_left_d = payload_left_q - {63'd0, (payload_left_q != 64'd0)};
				if (payload_left_d == 64'd0) begin
					res.emit         = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = data_byte;
					res.payload_last = 1'b1;
					phase_d          = PH_INITIAL;
				end else if (message_end) begin
					res.emit       = 1'b1;
					res.kind       = KIND_ERROR;
					res.error_code = ERR_TRUNCATED;
					phase_d        = PH_INITIAL;
				end else begin
					res.emit         = 1'b1;
					res.kind         = KIND_PAYLOAD;
					res.payload_byte = data_byte;
				end
			end
			PH_DROP: begin
				if (message_end)
					phase_d = PH_INITIAL;
			end
			default: phase_d = PH_INITIAL;
		endcase

		if (hd_go) begin
			res.emit = 1'b1;
			if ((hd_major == MAJOR_BYTES || hd_major == MAJOR_TEXT) && hd_arg != 64'd0) begin
				if (message_end) begin
					res.kind       = KIND_ERROR;
					res.error_code = ERR_TRUNCATED;
					phase_d        = PH_INITIAL;
				end else begin
					res.kind       = KIND_HEAD;
					res.major_type = hd_major;
					res.argument   = hd_arg;
					payload_left_d = hd_arg;
					phase_d        = PH_PAYLOAD;
				end
			end else begin
				res.kind       = KIND_HEAD;
				res.major_type = hd_major;
				res.argument   = hd_arg;
				phase_d        = PH_INITIAL;
			end
		end
	end

endmodule

@@ rtl/cbor_stream_head_decoder.sv @@
// cbor stream head decoder, top level with result register
// depends on csh_pkg and csh_decode
//
// usage: the input channel (data_valid, data_stall) carries one message byte per
// transfer in data_byte, with message_end high on the final byte of a message.
// the result channel (result_valid, result_stall) carries zero or one result per
// input byte: a decoded head (kind, major_type, argument), a string payload byte
// (payload_byte, payload_last) or an error (error_code).
// the result is registered and appears in the cycle after the byte that causes it.
// throughput: one byte per cycle while data_stall is low; the decode state update is
// limited by the 64-bit payload countdown and the argument shift.
// the block takes a new byte whenever the result register is empty or is being
// emptied in the same cycle; while the receiver stalls a held result, data_stall
// is high and the result stays unchanged.
// reset clears the result register and returns the decoder to expect an
// initial byte with all counters cleared.
module cbor_stream_head_decoder import csh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        data_valid,
	output logic        data_stall,
	input  logic [7:0]  data_byte,
	input  logic        message_end,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [1:0]  kind,
	output logic [2:0]  major_type,
	output logic [63:0] argument,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [1:0]  error_code
);

	logic    take;
	result_t res;
	result_t res_q;
	logic    valid_q;

	assign data_stall = valid_q & result_stall;
	assign take       = data_valid & ~data_stall;

	csh_decode u_decode (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.data_byte   (data_byte),
		.message_end (message_end),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (take) begin
			valid_q <= res.emit;
		end else if (valid_q && !result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else if (take && res.emit) begin
			res_q <= res;
		end
	end

	assign result_valid = valid_q;
	assign kind         = res_q.kind;
	assign major_type   = res_q.major_type;
	assign argument     = res_q.argument;
	assign payload_byte = res_q.payload_byte;
	assign payload_last = res_q.payload_last;
	assign error_code   = res_q.error_code;

endmodule

@@ rtl/csh_checker.sv @@
// port-level checks for cbor_stream_head_decoder, attached by bind
// depends on csh_pkg
module csh_checker import csh_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        data_stall,
	input logic        result_valid,
	input logic        result_stall,
	input logic [1:0]  kind,
	input logic [2:0]  major_type,
	input logic [63:0] argument,
	input logic [7:0]  payload_byte,
	input logic        payload_last,
	input logic [1:0]  error_code
);

	// a held result backs up the input side
	a_stall_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |-> data_stall)
		else $error("input not stalled behind a held result");

	// stalled result holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(kind)
			&& $stable(argument) && $stable(payload_byte) && $stable(error_code))
		else $error("stalled result changed");

	a_error_coded: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_ERROR |->
			(error_code == ERR_RESERVED || error_code == ERR_TRUNCATED)
			&& major_type == 3'd0 && argument == 64'd0)
		else $error("error result with bad fields");

	a_head_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_HEAD |->
			error_code == ERR_NONE && payload_last == 1'b0 && payload_byte == 8'd0)
		else $error("head result with payload or error fields");

	a_payload_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && kind == KIND_PAYLOAD |->
			error_code == ERR_NONE && argument == 64'd0)
		else $error("payload result with head or error fields");

endmodule

bind cbor_stream_head_decoder csh_checker u_csh_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.data_stall   (data_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.kind         (kind),
	.major_type   (major_type),
	.argument     (argument),
	.payload_byte (payload_byte),
	.payload_last (payload_last),
	.error_code   (error_code)
);
